/* design/tmv_pkg.sv */
// Shared types and constants for the transposed matrix-vector product.
// No dependencies.
package tmv_pkg;

    localparam int unsigned IN_W   = 16;
    localparam int unsigned PROD_W = 32;
    localparam int unsigned SUM_W  = 48;
    localparam int unsigned IDX_W  = 10;
    localparam int unsigned SIZE_W = 11;
    localparam int unsigned S_TDATA_W = 32;
    localparam int unsigned M_TDATA_W = 64;
    localparam int unsigned M_PAD_W   = M_TDATA_W - SUM_W - IDX_W;
    localparam int unsigned RESET_SIZE = 64;

    typedef struct packed {
        logic first_row;
        logic emit;
        logic last_col;
    } t_step_ctl;

endpackage

/* design/tmv_ctrl.sv */
// Row and column sequencer with the matrix size register.
// Depends on tmv_pkg.
module tmv_ctrl #(
    parameter int unsigned MAX_SIZE = 1024,
    parameter int unsigned IW       = 10
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [tmv_pkg::SIZE_W-1:0]  i_cfg_data,
    input  logic                        i_adv,
    output logic [IW-1:0]               o_col,
    output tmv_pkg::t_step_ctl          o_ctl
);
    import tmv_pkg::*;

    localparam int unsigned RESET_LAST =
        (RESET_SIZE < MAX_SIZE) ? RESET_SIZE - 1 : MAX_SIZE - 1;

    logic [IW-1:0] r_last, n_last;
    logic [IW-1:0] r_row, n_row;
    logic [IW-1:0] r_col, n_col;

    always_comb begin
        n_last = r_last;
        n_row  = r_row;
        n_col  = r_col;
        if (i_cfg_we) begin
            if (i_cfg_data == '0) begin
                n_last = '0;
            end else if (32'(i_cfg_data) > MAX_SIZE) begin
                n_last = IW'(MAX_SIZE - 1);
            end else begin
                n_last = IW'(32'(i_cfg_data) - 32'd1);
            end
            n_row = '0;
            n_col = '0;
        end else if (i_adv) begin
            if (r_col == r_last) begin
                n_col = '0;
                n_row = (r_row == r_last) ? '0 : r_row + IW'(1);
            end else begin
                n_col = r_col + IW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last <= IW'(RESET_LAST);
            r_row  <= '0;
            r_col  <= '0;
        end else begin
            r_last <= n_last;
            r_row  <= n_row;
            r_col  <= n_col;
        end
    end

    assign o_col          = r_col;
    assign o_ctl.first_row = (r_row == '0);
    assign o_ctl.emit      = (r_row == r_last);
    assign o_ctl.last_col  = (r_col == r_last);

endmodule

/* design/tmv_mac.sv */
// Multiply stage, column sum memory and read-modify-write accumulate stage.
// Depends on tmv_pkg.
module tmv_mac #(
    parameter int unsigned MAX_SIZE = 1024,
    parameter int unsigned IW       = 10
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_adv,
    input  logic [IW-1:0]                     i_col,
    input  tmv_pkg::t_step_ctl                i_ctl,
    input  logic signed [tmv_pkg::IN_W-1:0]   i_mat,
    input  logic signed [tmv_pkg::IN_W-1:0]   i_vec,
    input  logic                              i_move,
    output logic                              o_valid,
    output tmv_pkg::t_step_ctl                o_ctl,
    output logic [IW-1:0]                     o_col,
    output logic signed [tmv_pkg::SUM_W-1:0]  o_sum
);
    import tmv_pkg::*;

    logic [SUM_W-1:0]          r_mem [MAX_SIZE];
    logic [SUM_W-1:0]          r_rd;
    logic                      r_valid, n_valid;
    t_step_ctl                 r_ctl;
    logic [IW-1:0]             r_col;
    logic signed [PROD_W-1:0]  r_prod;
    logic signed [PROD_W-1:0]  prod;
    logic signed [SUM_W-1:0]   prod_ext;
    logic signed [SUM_W-1:0]   sum;

    assign prod = i_mat * i_vec;

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_rd   <= r_mem[i_col];
            r_ctl  <= i_ctl;
            r_col  <= i_col;
            r_prod <= prod;
        end
        if (r_valid && i_move) begin
            r_mem[r_col] <= sum;
        end
    end

    always_comb begin
        n_valid = r_valid;
        if (i_adv) begin
            n_valid = 1'b1;
        end else if (i_move) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    assign prod_ext = {{(SUM_W - PROD_W){r_prod[PROD_W-1]}}, r_prod};
    assign sum      = r_ctl.first_row ? prod_ext : $signed(r_rd) + prod_ext;

    assign o_valid = r_valid;
    assign o_ctl   = r_ctl;
    assign o_col   = r_col;
    assign o_sum   = sum;

endmodule

/* design/transposed_matrix_vector_product.sv */
// Top level of the transposed matrix-vector product.
// Depends on tmv_pkg, tmv_ctrl and tmv_mac.
//
// Usage:
//   s_axis carries one matrix element per word in row-major order, with the
//   vector entry of that element's row. m_axis returns one completed column
//   sum per word during the last row of each matrix; tlast marks the final
//   column. The cfg channel writes the matrix size (0 acts as 1, values above
//   MAX_SIZE act as MAX_SIZE); a write restarts the row and column counters.
//   A result passes through the accumulate stage and the output register on
//   its way to m_axis. Throughput: one element per cycle unless a result
//   stalls in the accumulate stage, set by the single read-modify-write
//   port pair of the column sum memory (read at accept, write on move).
//   Reset: counters clear, size returns to 64 (or MAX_SIZE if smaller), no
//   word is held. The sum memory needs no clearing: row 0 overwrites it.
//   Stall: when m_axis is full and not taken, a pending result holds in the
//   accumulate stage and s_axis_tready drops; elements that produce no
//   result keep flowing while the output register waits.
module transposed_matrix_vector_product #(
    parameter int unsigned MAX_SIZE = 1024
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // [15:0] matrix_value, [31:16] vector_value
    input  logic [tmv_pkg::S_TDATA_W-1:0]     s_axis_tdata,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // [47:0] result_value, [57:48] result_index, [63:58] zero
    output logic [tmv_pkg::M_TDATA_W-1:0]     m_axis_tdata,
    output logic                              m_axis_tlast,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [tmv_pkg::SIZE_W-1:0]        i_cfg_data
);
    import tmv_pkg::*;

    localparam int unsigned IW = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1;

    logic               accept;
    logic               cfg_we;
    logic [IW-1:0]      col;
    t_step_ctl          ctl;
    logic               s1_valid;
    t_step_ctl          s1_ctl;
    logic [IW-1:0]      s1_col;
    logic signed [SUM_W-1:0] s1_sum;
    logic               s1_move;

    logic               r_ovalid, n_ovalid;
    logic [SUM_W-1:0]   r_osum;
    logic [IDX_W-1:0]   r_oidx;
    logic               r_olast;

    assign o_cfg_ready = 1'b1;
    assign cfg_we      = i_cfg_valid;

    assign s1_move = s1_valid && (!s1_ctl.emit || !r_ovalid || m_axis_tready);
    assign s_axis_tready = !s1_valid || s1_move;
    assign accept = s_axis_tvalid && s_axis_tready;

    tmv_ctrl #(
        .MAX_SIZE (MAX_SIZE),
        .IW       (IW)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_adv      (accept),
        .o_col      (col),
        .o_ctl      (ctl)
    );

    tmv_mac #(
        .MAX_SIZE (MAX_SIZE),
        .IW       (IW)
    ) u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (accept),
        .i_col   (col),
        .i_ctl   (ctl),
        .i_mat   (s_axis_tdata[IN_W-1:0]),
        .i_vec   (s_axis_tdata[2*IN_W-1:IN_W]),
        .i_move  (s1_move),
        .o_valid (s1_valid),
        .o_ctl   (s1_ctl),
        .o_col   (s1_col),
        .o_sum   (s1_sum)
    );

    always_comb begin
        n_ovalid = r_ovalid;
        if (s1_move && s1_ctl.emit) begin
            n_ovalid = 1'b1;
        end else if (m_axis_tready) begin
            n_ovalid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else begin
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_move && s1_ctl.emit) begin
            r_osum  <= s1_sum;
            r_oidx  <= IDX_W'(s1_col);
            r_olast <= s1_ctl.last_col;
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {{M_PAD_W{1'b0}}, r_oidx, r_osum};
    assign m_axis_tlast  = r_olast;

    a_accept_fills_stage: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> s1_valid)
        else $error("accepted word missing from accumulate stage");

    a_stall_holds_stage: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_valid && !s1_move) |=> (s1_valid && $stable(s1_col)))
        else $error("stalled accumulate stage dropped its word");

    a_cfg_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cfg_valid && o_cfg_ready) |=> (col == '0 && ctl.first_row))
        else $error("size write did not restart the counters");

endmodule

/* verif/tb_top.sv */
// Self-checking testbench for transposed_matrix_vector_product.
// Streams matrices with random idling on both sides and predicts the column sums.
// Depends on tmv_pkg and the transposed_matrix_vector_product RTL.
module tb_top;
    import tmv_pkg::*;

    localparam int unsigned MAX_SIZE = 1024;

    typedef struct {
        logic [SUM_W-1:0] value;
        logic [IDX_W-1:0] index;
        logic             last;
    } t_column_result;

    class t_tmv_scoreboard;
        logic signed [SUM_W-1:0] column_sums [MAX_SIZE];
        int unsigned             row_pos;
        int unsigned             col_pos;
        logic [SIZE_W-1:0]       size_reg = SIZE_W'(RESET_SIZE);
        t_column_result          expected_q [$];
        int                      errors;
        int                      results_seen;

        function int pending();
            return expected_q.size();
        endfunction

        task report_mismatch(string msg);
            errors++;
            $display("MISMATCH at %0t: %s", $realtime, msg);
        endtask

        function void load_size(logic [SIZE_W-1:0] value);
            size_reg = value;
            row_pos  = 0;
            col_pos  = 0;
        endfunction

        function void note_element(logic signed [IN_W-1:0] mat, logic signed [IN_W-1:0] vec);
            int unsigned             eff;
            logic signed [SUM_W-1:0] prod;
            logic signed [SUM_W-1:0] sum;
            t_column_result          res;
            eff = (size_reg == 0) ? 1 : (size_reg > MAX_SIZE) ? MAX_SIZE : size_reg;
            if (col_pos >= eff) col_pos = 0;
            if (row_pos >= eff) row_pos = 0;
            prod = mat * vec;
            sum  = (row_pos == 0) ? prod : column_sums[col_pos] + prod;
            column_sums[col_pos] = sum;
            if (row_pos == eff - 1) begin
                res.value = sum;
                res.index = IDX_W'(col_pos);
                res.last  = (col_pos == eff - 1);
                expected_q.push_back(res);
            end
            col_pos++;
            if (col_pos >= eff) begin
                col_pos = 0;
                row_pos++;
                if (row_pos >= eff) row_pos = 0;
            end
        endfunction

        task check_result(logic [SUM_W-1:0] value, logic [IDX_W-1:0] index, logic last);
            t_column_result exp_res;
            results_seen++;
            if (expected_q.size() == 0) begin
                report_mismatch($sformatf("unexpected word index %0d value %0h", index, value));
                return;
            end
            exp_res = expected_q.pop_front();
            if (value !== exp_res.value)
                report_mismatch($sformatf("column %0d sum %0h, expected %0h",
                                          exp_res.index, value, exp_res.value));
            if (index !== exp_res.index)
                report_mismatch($sformatf("index %0d, expected %0d", index, exp_res.index));
            if (last !== exp_res.last)
                report_mismatch($sformatf("column %0d tlast %b, expected %b",
                                          exp_res.index, last, exp_res.last));
        endtask
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [S_TDATA_W-1:0]  s_axis_tdata;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [M_TDATA_W-1:0]  m_axis_tdata;
    logic                  m_axis_tlast;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [SIZE_W-1:0]     i_cfg_data;

    t_tmv_scoreboard sb = new();
    bit            quiet_mode;
    int            elements_sent;
    int            cfg_writes;
    int            random_elements;

    transposed_matrix_vector_product #(
        .MAX_SIZE(MAX_SIZE)
    ) u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tlast (m_axis_tlast),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    function automatic int draw_gap();
        if (quiet_mode || $urandom_range(0, 2) == 0)
            return 0;
        return $urandom_range(0, 17);
    endfunction

    function automatic logic [IN_W-1:0] draw_value();
        case ($urandom_range(0, 7))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'hffff;
            3: return 16'h0000;
            default: return IN_W'($urandom());
        endcase
    endfunction

    task automatic send_element(input logic [IN_W-1:0] mat, input logic [IN_W-1:0] vec);
        int gap;
        gap = draw_gap();
        @(negedge i_clk);
        if (gap != 0) begin
            s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = {vec, mat};
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_element(mat, vec);
        elements_sent++;
    endtask

    task automatic send_random_elements(input int count);
        repeat (count) send_element(draw_value(), draw_value());
    endtask

    // Drain, then let in-flight words settle before touching the size register.
    task automatic write_size(input logic [SIZE_W-1:0] value);
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        while (sb.pending() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_data  = value;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.load_size(value);
        cfg_writes++;
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata[SUM_W-1:0], m_axis_tdata[SUM_W+IDX_W-1:SUM_W],
                            m_axis_tlast);
    end

    initial begin
        int stall;
        m_axis_tready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            stall = draw_gap();
            @(negedge i_clk);
            if (stall != 0) begin
                m_axis_tready = 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            m_axis_tready = 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
        end
    end

    initial begin
        #8_000_000;
        $display("timeout: %0d words still expected", sb.pending());
        $display("transposed_matrix_vector_product regression: fail");
        $finish;
    end

    initial begin
        int n;
        int kind;
        int reps;
        int pick;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        i_cfg_valid   = 1'b0;
        i_cfg_data    = '0;
        i_rst_n       = 1'b0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Two rows at the size left by reset: nothing emits before the last row.
        send_random_elements(2 * RESET_SIZE);

        // Size zero behaves as one.
        write_size(11'd0);
        send_element(16'h8000, 16'h8000);
        send_element(16'h7fff, 16'h8000);

        // Extreme products accumulate past 32 bits.
        write_size(11'd3);
        for (int i = 0; i < 9; i++)
            send_element((i % 3 == 1) ? 16'h7fff : 16'h8000, (i < 6) ? 16'h8000 : 16'hffff);

        // Oversize values clamp to the maximum; partial rows emit nothing.
        write_size(11'd2047);
        send_random_elements(2);
        write_size(11'd1025);
        send_random_elements(1);
        write_size(11'd1024);
        send_random_elements(1);

        // A write mid-matrix restarts the counters.
        write_size(11'd2);
        send_random_elements(3);
        write_size(11'd2);
        send_random_elements(4);

        while (random_elements < 520) begin
            quiet_mode = ($urandom_range(0, 3) == 0);
            kind = $urandom_range(0, 9);
            if (kind < 7) begin
                pick = $urandom_range(0, 19);
                if (pick <= 12)
                    n = $urandom_range(1, 5);
                else if (pick <= 18)
                    n = $urandom_range(6, 12);
                else
                    n = $urandom_range(13, 20);
                reps = (n <= 5) ? $urandom_range(1, 3) : 1;
                write_size((n == 1 && $urandom_range(0, 1) == 0) ? 11'd0 : SIZE_W'(n));
                send_random_elements(reps * n * n);
                random_elements += reps * n * n;
            end else if (kind < 9) begin
                n = $urandom_range(2, 8);
                write_size(SIZE_W'(n));
                reps = $urandom_range(1, n * n - 1);
                send_random_elements(reps);
                random_elements += reps;
            end else begin
                write_size(SIZE_W'($urandom_range(MAX_SIZE + 1, 2047)));
                reps = $urandom_range(1, 20);
                send_random_elements(reps);
                random_elements += reps;
            end
        end

        quiet_mode = 1'b0;
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        $display("sent %0d matrix elements across %0d size writes (sizes 0 to 2047)",
                 elements_sent, cfg_writes);
        $display("checked %0d column sums, %0d mismatches", sb.results_seen, sb.errors);
        if (sb.errors == 0)
            $display("transposed_matrix_vector_product regression: pass");
        else
            $display("transposed_matrix_vector_product regression: fail");
        $finish;
    end

endmodule

/* files.f */
design/tmv_pkg.sv
design/tmv_ctrl.sv
design/tmv_mac.sv
design/transposed_matrix_vector_product.sv
verif/tb_top.sv
